// File: hw/rtl/rpmc_pkg.sv
package rpmc_pkg;

    localparam int MAX_ROOMS       = 64;
    localparam int WALL_LIST_DEPTH = 256;

    localparam int DIM_W      = 4;
    localparam int DIM_MAX    = 8;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int WALL_W     = 4;
    localparam int RND_W      = 31;
    localparam int MODE_W     = 2;
    localparam int SEL_W      = 6;
    localparam int OUT_ROOM_W = 6;
    localparam int PEND_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int PUSH_CNT_W = 2;

    localparam int ROOM_W    = $clog2(MAX_ROOMS);
    localparam int ROOMS_W   = $clog2(MAX_ROOMS + 1);
    localparam int LIST_AW   = $clog2(WALL_LIST_DEPTH);
    localparam int LEN_W     = $clog2(WALL_LIST_DEPTH + 1);
    localparam int ENTRY_W   = ROOM_W + WALL_W;
    localparam int DVS_W     = (LEN_W > ROOMS_W) ? LEN_W : ROOMS_W;
    localparam int NI_W      = ((ROOM_W > DIM_W) ? ROOM_W : DIM_W) + 1;
    localparam int DIV_CNT_W = $clog2(RND_W);

    typedef logic [WALL_W-1:0] t_walls;

    localparam t_walls SIDE_N_BIT = 4'h1;
    localparam t_walls SIDE_E_BIT = 4'h2;
    localparam t_walls SIDE_S_BIT = 4'h4;
    localparam t_walls SIDE_W_BIT = 4'h8;
    localparam t_walls ALL_WALLS  = 4'hF;

    typedef enum logic [MODE_W-1:0] {
        MODE_START,
        MODE_STEP,
        MODE_READ,
        MODE_NONE
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_DIV,
        S_PICK_DIV,
        S_ENTRY,
        S_GEOM_DIV,
        S_RD_CI,
        S_RD_NI,
        S_WR_NI,
        S_PUSH,
        S_LAST_RD,
        S_LAST_WR,
        S_RD_SEL,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_walls walls;
        logic   visited;
    } t_room;

    typedef struct packed {
        logic              start;
        logic [RND_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RND_W-1:0]  quotient;
        logic [DVS_W-1:0]  remainder;
    } t_div_res;

    typedef struct packed {
        logic              clear;
        logic [ROOM_W-1:0] rd_addr;
        logic              we;
        logic [ROOM_W-1:0] wr_addr;
        t_room             wr_data;
    } t_room_req;

    typedef struct packed {
        logic                  carved;
        logic [OUT_ROOM_W-1:0] room_index;
        logic [OUT_ROOM_W-1:0] neighbour_index;
        t_walls                room_walls;
        t_walls                neighbour_walls;
        logic                  visited;
        logic [PEND_W-1:0]     pending;
        logic                  done_res;
        logic                  bad_index;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > DIM_MAX) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/rpmc_in_if.sv
interface rpmc_in_if;
    logic                         valid;
    logic                         ready;
    logic [rpmc_pkg::MODE_W-1:0]  mode;
    logic [rpmc_pkg::RND_W-1:0]   random_value;
    logic [rpmc_pkg::SEL_W-1:0]   room_select;

    modport source (output valid, output mode, output random_value, output room_select,
                    input ready);
    modport sink (input valid, input mode, input random_value, input room_select,
                  output ready);
endinterface

// File: hw/rtl/rpmc_out_if.sv
interface rpmc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             carved;
    logic [rpmc_pkg::OUT_ROOM_W-1:0]  room_index;
    logic [rpmc_pkg::OUT_ROOM_W-1:0]  neighbour_index;
    logic [rpmc_pkg::WALL_W-1:0]      room_walls;
    logic [rpmc_pkg::WALL_W-1:0]      neighbour_walls;
    logic                             visited;
    logic [rpmc_pkg::PEND_W-1:0]      pending;
    logic                             done_res;
    logic                             bad_index;

    modport source (output valid, output carved, output room_index, output neighbour_index,
                    output room_walls, output neighbour_walls, output visited,
                    output pending, output done_res, output bad_index, input ready);
    modport sink (input valid, input carved, input room_index, input neighbour_index,
                  input room_walls, input neighbour_walls, input visited,
                  input pending, input done_res, input bad_index, output ready);
endinterface

// File: hw/rtl/rpmc_div.sv
module rpmc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpmc_pkg::t_div_req i_req,
    output rpmc_pkg::t_div_res o_res
);

    logic                                r_busy;
    logic                                r_done;
    logic [rpmc_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [rpmc_pkg::RND_W-1:0]          r_quo;
    logic [rpmc_pkg::DVS_W-1:0]          r_rem;
    logic [rpmc_pkg::DVS_W-1:0]          r_dvs;
    logic [rpmc_pkg::DVS_W:0]            trial;
    logic [rpmc_pkg::DVS_W:0]            diff;
    logic                                fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign trial = {r_rem, r_quo[rpmc_pkg::RND_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rpmc_pkg::DIV_CNT_W'(1);
                if (r_cnt == rpmc_pkg::DIV_CNT_W'(rpmc_pkg::RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[rpmc_pkg::RND_W-2:0], fits};
            r_rem <= fits ? diff[rpmc_pkg::DVS_W-1:0] : trial[rpmc_pkg::DVS_W-1:0];
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

// File: hw/rtl/rpmc_room_mem.sv
module rpmc_room_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpmc_pkg::t_room_req i_req,
    output rpmc_pkg::t_room     o_rd
);

    logic [rpmc_pkg::MAX_ROOMS-1:0] r_valid;
    rpmc_pkg::t_room                r_mem [rpmc_pkg::MAX_ROOMS];
    rpmc_pkg::t_room                r_q;
    logic                           r_qv;

    // A room never written since the last clear reads as four walls, unvisited.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            r_qv <= r_valid[i_req.rd_addr];
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_q <= r_mem[i_req.rd_addr];
    end

    always_comb begin
        if (r_qv) begin
            o_rd = r_q;
        end else begin
            o_rd.walls   = rpmc_pkg::ALL_WALLS;
            o_rd.visited = 1'b0;
        end
    end

endmodule

// File: hw/rtl/random_prim_maze_carver_unit.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    mode, random_value, room_select
// o_res     out  valid/ready    carved, room_index, neighbour_index, room_walls,
//                               neighbour_walls, visited, pending, done_res, bad_index
// i_cfg_*   in   write enable   i_cfg_idx selects grid width or height, i_cfg_data
//
// One item at a time. A start runs the bit-serial divider once and a step with a non-empty
// wall list twice; an empty-list step, an unused mode or a read needs no divider pass.
// Reset needs no clearing pass: per-room valid bits return every room to four walls. A
// finished result waits in the output register while the next item runs; the next result
// then holds the sequencer until the waiting one is taken.
module random_prim_maze_carver_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rpmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rpmc_in_if.sink                           i_in,
    rpmc_out_if.source                        o_res
);

    rpmc_pkg::t_state                  r_state;
    rpmc_pkg::t_state                  n_state;
    logic [rpmc_pkg::DIM_W-1:0]        r_grid_w;
    logic [rpmc_pkg::DIM_W-1:0]        r_grid_h;
    logic [rpmc_pkg::LEN_W-1:0]        r_len;
    logic                              r_out_valid;
    rpmc_pkg::t_result                 r_out;

    rpmc_pkg::t_mode                   r_mode;
    logic [rpmc_pkg::ROOM_W-1:0]       r_ci;
    rpmc_pkg::t_walls                  r_cw;
    logic [rpmc_pkg::ROOM_W-1:0]       r_ni;
    logic                              r_inside;
    logic [rpmc_pkg::LIST_AW-1:0]      r_pick;
    rpmc_pkg::t_walls                  r_cwalls;
    logic                              r_cvis;
    logic                              r_carved;
    logic [rpmc_pkg::OUT_ROOM_W-1:0]   r_ridx;
    rpmc_pkg::t_walls                  r_rwalls;
    rpmc_pkg::t_walls                  r_nwalls;
    logic                              r_vis;
    logic                              r_bad;
    logic [rpmc_pkg::ROOM_W-1:0]       r_push_room;
    rpmc_pkg::t_walls                  r_push_walls;
    logic [rpmc_pkg::PUSH_CNT_W-1:0]   r_bit;

    logic [rpmc_pkg::ENTRY_W-1:0]      r_list [rpmc_pkg::WALL_LIST_DEPTH];
    logic [rpmc_pkg::ENTRY_W-1:0]      r_list_q;
    logic                              list_we;
    logic [rpmc_pkg::LIST_AW-1:0]      list_waddr;
    logic [rpmc_pkg::ENTRY_W-1:0]      list_wdata;
    logic [rpmc_pkg::LIST_AW-1:0]      list_raddr;

    rpmc_pkg::t_div_req                div_req;
    rpmc_pkg::t_div_res                div_res;
    rpmc_pkg::t_room_req               room_req;
    rpmc_pkg::t_room                   room_rd;

    logic [rpmc_pkg::DIM_W-1:0]        w_dim;
    logic [rpmc_pkg::DIM_W-1:0]        h_dim;
    logic [rpmc_pkg::PROD_W-1:0]       prod;
    logic [rpmc_pkg::ROOMS_W-1:0]      rooms;
    rpmc_pkg::t_mode                   in_mode;
    logic                              in_fire;
    logic                              out_free;
    logic                              sel_bad;
    logic                              carve;
    logic                              push_ok;
    rpmc_pkg::t_walls                  push_bit;
    rpmc_pkg::t_walls                  opp;
    rpmc_pkg::t_walls                  ni_walls;
    logic [rpmc_pkg::LEN_W-1:0]        len_m1;
    logic [rpmc_pkg::DVS_W:0]          x_p1;
    logic [rpmc_pkg::NI_W-1:0]         ci_x;
    logic [rpmc_pkg::NI_W-1:0]         w_x;
    logic [rpmc_pkg::NI_W-1:0]         ni_x;
    logic                              geo_in;
    logic                              geo_inside;
    logic [rpmc_pkg::ROOM_W-1:0]       entry_room;

    rpmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    rpmc_room_mem u_room_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (room_req),
        .o_rd    (room_rd)
    );

    // Geometry and shared conditions.
    assign w_dim = rpmc_pkg::clamp_dim(r_grid_w);
    assign h_dim = rpmc_pkg::clamp_dim(r_grid_h);
    assign prod  = rpmc_pkg::PROD_W'(w_dim) * rpmc_pkg::PROD_W'(h_dim);
    assign rooms = (32'(prod) > rpmc_pkg::MAX_ROOMS) ? rpmc_pkg::ROOMS_W'(rpmc_pkg::MAX_ROOMS)
                                                     : rpmc_pkg::ROOMS_W'(prod);

    assign i_in.ready = (r_state == rpmc_pkg::S_IDLE);
    assign in_mode  = rpmc_pkg::t_mode'(i_in.mode);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign sel_bad  = 32'(i_in.room_select) >= 32'(rooms);
    assign carve    = r_inside && !room_rd.visited;
    assign push_bit = rpmc_pkg::t_walls'(1) << r_bit;
    assign push_ok  = r_push_walls[r_bit] && (r_len < rpmc_pkg::LEN_W'(rpmc_pkg::WALL_LIST_DEPTH));
    assign opp      = {r_cw[1:0], r_cw[3:2]};
    assign ni_walls = room_rd.walls & ~opp;
    assign len_m1   = r_len - rpmc_pkg::LEN_W'(1);
    assign entry_room = r_list_q[rpmc_pkg::ENTRY_W-1:rpmc_pkg::WALL_W];

    // Neighbour across the picked wall, from x = ci % w and y = ci / w.
    assign x_p1 = {1'b0, div_res.remainder} + {{rpmc_pkg::DVS_W{1'b0}}, 1'b1};
    assign ci_x = rpmc_pkg::NI_W'(r_ci);
    assign w_x  = rpmc_pkg::NI_W'(w_dim);

    always_comb begin
        geo_in = 1'b0;
        ni_x   = '0;
        priority if (r_cw == rpmc_pkg::SIDE_N_BIT && div_res.quotient != '0) begin
            geo_in = 1'b1;
            ni_x   = ci_x - w_x;
        end else if (r_cw == rpmc_pkg::SIDE_E_BIT &&
                     x_p1 < (rpmc_pkg::DVS_W + 1)'(w_dim)) begin
            geo_in = 1'b1;
            ni_x   = ci_x + rpmc_pkg::NI_W'(1);
        end else if (r_cw == rpmc_pkg::SIDE_S_BIT) begin
            geo_in = 1'b1;
            ni_x   = ci_x + w_x;
        end else if (r_cw == rpmc_pkg::SIDE_W_BIT && div_res.remainder != '0) begin
            geo_in = 1'b1;
            ni_x   = ci_x - rpmc_pkg::NI_W'(1);
        end else begin
            geo_in = 1'b0;
        end
    end

    assign geo_inside = geo_in && (32'(ni_x) < 32'(rooms));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpmc_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (in_mode)
                        rpmc_pkg::MODE_START: n_state = rpmc_pkg::S_START_DIV;
                        rpmc_pkg::MODE_STEP: begin
                            n_state = (r_len != '0) ? rpmc_pkg::S_PICK_DIV
                                                    : rpmc_pkg::S_FINISH;
                        end
                        rpmc_pkg::MODE_READ: begin
                            n_state = sel_bad ? rpmc_pkg::S_FINISH : rpmc_pkg::S_RD_SEL;
                        end
                        rpmc_pkg::MODE_NONE: n_state = rpmc_pkg::S_FINISH;
                        default: n_state = rpmc_pkg::S_FINISH;
                    endcase
                end
            end
            rpmc_pkg::S_START_DIV: begin
                if (div_res.done) n_state = rpmc_pkg::S_PUSH;
            end
            rpmc_pkg::S_PICK_DIV: begin
                if (div_res.done) n_state = rpmc_pkg::S_ENTRY;
            end
            rpmc_pkg::S_ENTRY: n_state = rpmc_pkg::S_GEOM_DIV;
            rpmc_pkg::S_GEOM_DIV: begin
                if (div_res.done) n_state = rpmc_pkg::S_RD_CI;
            end
            rpmc_pkg::S_RD_CI: n_state = rpmc_pkg::S_RD_NI;
            rpmc_pkg::S_RD_NI: n_state = carve ? rpmc_pkg::S_WR_NI : rpmc_pkg::S_LAST_RD;
            rpmc_pkg::S_WR_NI: n_state = rpmc_pkg::S_PUSH;
            rpmc_pkg::S_PUSH: begin
                if (r_bit == {rpmc_pkg::PUSH_CNT_W{1'b1}}) begin
                    n_state = (r_mode == rpmc_pkg::MODE_START) ? rpmc_pkg::S_FINISH
                                                               : rpmc_pkg::S_LAST_RD;
                end
            end
            rpmc_pkg::S_LAST_RD: n_state = rpmc_pkg::S_LAST_WR;
            rpmc_pkg::S_LAST_WR: n_state = rpmc_pkg::S_FINISH;
            rpmc_pkg::S_RD_SEL: n_state = rpmc_pkg::S_FINISH;
            rpmc_pkg::S_FINISH: begin
                if (out_free) n_state = rpmc_pkg::S_IDLE;
            end
            default: n_state = rpmc_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: divider, room store and wall list controls.
    always_comb begin
        div_req    = '0;
        room_req   = '0;
        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        list_raddr = '0;
        unique case (r_state)
            rpmc_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (in_mode == rpmc_pkg::MODE_START) begin
                        room_req.clear   = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = i_in.random_value;
                        div_req.divisor  = rpmc_pkg::DVS_W'(rooms);
                    end else if (in_mode == rpmc_pkg::MODE_STEP && r_len != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = i_in.random_value;
                        div_req.divisor  = rpmc_pkg::DVS_W'(r_len);
                    end else if (in_mode == rpmc_pkg::MODE_READ) begin
                        room_req.rd_addr = rpmc_pkg::ROOM_W'(i_in.room_select);
                    end
                end
            end
            rpmc_pkg::S_START_DIV: begin
                if (div_res.done) begin
                    room_req.we              = 1'b1;
                    room_req.wr_addr         = rpmc_pkg::ROOM_W'(div_res.remainder);
                    room_req.wr_data.walls   = rpmc_pkg::ALL_WALLS;
                    room_req.wr_data.visited = 1'b1;
                end
            end
            rpmc_pkg::S_PICK_DIV: begin
                list_raddr = rpmc_pkg::LIST_AW'(div_res.remainder);
            end
            rpmc_pkg::S_ENTRY: begin
                div_req.start    = 1'b1;
                div_req.dividend = rpmc_pkg::RND_W'(entry_room);
                div_req.divisor  = rpmc_pkg::DVS_W'(w_dim);
            end
            rpmc_pkg::S_GEOM_DIV: begin
                room_req.rd_addr = r_ci;
            end
            rpmc_pkg::S_RD_CI: begin
                room_req.rd_addr = r_ni;
            end
            rpmc_pkg::S_RD_NI: begin
                if (carve) begin
                    room_req.we              = 1'b1;
                    room_req.wr_addr         = r_ci;
                    room_req.wr_data.walls   = r_cwalls & ~r_cw;
                    room_req.wr_data.visited = r_cvis;
                end
            end
            rpmc_pkg::S_WR_NI: begin
                room_req.we              = 1'b1;
                room_req.wr_addr         = r_ni;
                room_req.wr_data.walls   = r_nwalls;
                room_req.wr_data.visited = 1'b1;
            end
            rpmc_pkg::S_PUSH: begin
                if (push_ok) begin
                    list_we    = 1'b1;
                    list_waddr = rpmc_pkg::LIST_AW'(r_len);
                    list_wdata = {r_push_room, push_bit};
                end
            end
            rpmc_pkg::S_LAST_RD: begin
                list_raddr = rpmc_pkg::LIST_AW'(len_m1);
            end
            rpmc_pkg::S_LAST_WR: begin
                // The last entry moves into the hole left by the picked one.
                list_we    = 1'b1;
                list_waddr = r_pick;
                list_wdata = r_list_q;
            end
            rpmc_pkg::S_RD_SEL: begin
                list_we = 1'b0;
            end
            rpmc_pkg::S_FINISH: begin
                list_we = 1'b0;
            end
            default: begin
                list_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_list[list_waddr] <= list_wdata;
        end
        r_list_q <= r_list[list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpmc_pkg::S_IDLE;
            r_grid_w    <= rpmc_pkg::DIM_W'(5);
            r_grid_h    <= rpmc_pkg::DIM_W'(5);
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (rpmc_pkg::t_cfg_idx'(i_cfg_idx))
                    rpmc_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    rpmc_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                    default:                   r_grid_w <= r_grid_w;
                endcase
            end
            if (r_state == rpmc_pkg::S_IDLE && in_fire && in_mode == rpmc_pkg::MODE_START) begin
                r_len <= '0;
            end else if (list_we && r_state == rpmc_pkg::S_PUSH) begin
                r_len <= r_len + rpmc_pkg::LEN_W'(1);
            end else if (r_state == rpmc_pkg::S_LAST_RD) begin
                r_len <= len_m1;
            end
            if (r_state == rpmc_pkg::S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rpmc_pkg::S_IDLE: begin
                if (in_fire) begin
                    r_mode   <= in_mode;
                    r_carved <= 1'b0;
                    r_rwalls <= '0;
                    r_nwalls <= '0;
                    r_vis    <= 1'b0;
                    r_bad    <= (in_mode == rpmc_pkg::MODE_READ) && sel_bad;
                    r_ridx   <= (in_mode == rpmc_pkg::MODE_READ) ? i_in.room_select : '0;
                end
            end
            rpmc_pkg::S_START_DIV: begin
                if (div_res.done) begin
                    r_push_room  <= rpmc_pkg::ROOM_W'(div_res.remainder);
                    r_push_walls <= rpmc_pkg::ALL_WALLS;
                    r_bit        <= '0;
                    r_rwalls     <= rpmc_pkg::ALL_WALLS;
                    r_ridx       <= rpmc_pkg::OUT_ROOM_W'(div_res.remainder);
                end
            end
            rpmc_pkg::S_PICK_DIV: begin
                if (div_res.done) begin
                    r_pick <= rpmc_pkg::LIST_AW'(div_res.remainder);
                end
            end
            rpmc_pkg::S_ENTRY: begin
                r_ci   <= entry_room;
                r_cw   <= r_list_q[rpmc_pkg::WALL_W-1:0];
                r_ridx <= rpmc_pkg::OUT_ROOM_W'(entry_room);
            end
            rpmc_pkg::S_GEOM_DIV: begin
                if (div_res.done) begin
                    r_ni     <= rpmc_pkg::ROOM_W'(ni_x);
                    r_inside <= geo_inside;
                end
            end
            rpmc_pkg::S_RD_CI: begin
                r_cwalls <= room_rd.walls;
                r_cvis   <= room_rd.visited;
            end
            rpmc_pkg::S_RD_NI: begin
                if (carve) begin
                    r_carved     <= 1'b1;
                    r_rwalls     <= r_cwalls & ~r_cw;
                    r_nwalls     <= ni_walls;
                    r_push_room  <= r_ni;
                    r_push_walls <= ni_walls;
                    r_bit        <= '0;
                end else begin
                    r_rwalls <= r_cwalls;
                end
            end
            rpmc_pkg::S_PUSH: begin
                r_bit <= r_bit + rpmc_pkg::PUSH_CNT_W'(1);
            end
            rpmc_pkg::S_RD_SEL: begin
                r_rwalls <= room_rd.walls;
                r_vis    <= room_rd.visited;
            end
            rpmc_pkg::S_FINISH: begin
                if (out_free) begin
                    r_out.carved          <= r_carved;
                    r_out.room_index      <= r_ridx;
                    r_out.neighbour_index <= r_carved ? rpmc_pkg::OUT_ROOM_W'(r_ni) : '0;
                    r_out.room_walls      <= r_rwalls;
                    r_out.neighbour_walls <= r_nwalls;
                    r_out.visited         <= r_vis;
                    r_out.pending         <= rpmc_pkg::PEND_W'(r_len);
                    r_out.done_res        <= (r_len == '0);
                    r_out.bad_index       <= r_bad;
                end
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.carved          = r_out.carved;
    assign o_res.room_index      = r_out.room_index;
    assign o_res.neighbour_index = r_out.neighbour_index;
    assign o_res.room_walls      = r_out.room_walls;
    assign o_res.neighbour_walls = r_out.neighbour_walls;
    assign o_res.visited         = r_out.visited;
    assign o_res.pending         = r_out.pending;
    assign o_res.done_res        = r_out.done_res;
    assign o_res.bad_index       = r_out.bad_index;

endmodule
